@@ design/alp_pkg.sv @@
`default_nettype none

package alp_pkg;

   localparam int BYTE_W     = 8;
   localparam int USEC_W     = 20;
   localparam int VALUE_W    = 32;
   localparam int COUNTER_W  = 16;
   localparam int CC_W       = 4;
   localparam int PROD_W     = COUNTER_W + USEC_W;
   localparam int TOFF_W     = PROD_W + 1;
   localparam int CHAN_NUM_W = 3;
   localparam int MAX_CHAN   = 8;
   localparam int MASK_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [BYTE_W-1:0] HASH_CHAR  = 8'h23;
   localparam logic [BYTE_W-1:0] COMMA_CHAR = 8'h2C;
   localparam logic [CC_W-1:0]   CC_MAX     = 4'hF;

   localparam logic signed [TOFF_W-1:0] FAR_LIMIT_USEC  = 37'sd900000;
   localparam logic signed [TOFF_W-1:0] NEAR_START_USEC = 37'sd100000;
   localparam logic signed [TOFF_W-1:0] SECOND_USEC     = 37'sd1000000;

   localparam logic [USEC_W-1:0] PERIOD_RESET = 20'd10000;

   localparam logic [1:0] LS_GOOD     = 2'd0;
   localparam logic [1:0] LS_BAD_SUM  = 2'd1;
   localparam logic [1:0] LS_NO_COMMA = 2'd2;

   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHECKSUM_ENABLE = 2'd0,
      CSR_PPS_LOCKED      = 2'd1,
      CSR_SAMPLE_PERIOD   = 2'd2,
      CSR_CHANNEL_MASK    = 2'd3
   } alp_csr_type;

   typedef struct packed {
      logic                 ok;
      logic [3:0]           digit;
   } alp_hex_type;

   typedef struct packed {
      logic                 start;
      logic                 pps;
      logic [COUNTER_W-1:0] counter;
      logic [USEC_W-1:0]    period;
      logic [USEC_W-1:0]    arrival;
   } alp_time_req_type;

   function automatic alp_hex_type hex_decode(input logic [BYTE_W-1:0] b);
      alp_hex_type h;
      h.ok    = 1'b1;
      h.digit = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.digit = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.digit = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.digit = 4'(b - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

@@ design/alp_req_if.sv @@
`default_nettype none

interface alp_req_if import alp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] line_byte;
   logic              end_of_line;
   logic [USEC_W-1:0] arrival_usec;

   modport source (output valid, line_byte, end_of_line, arrival_usec, input ready);
   modport sink (input valid, line_byte, end_of_line, arrival_usec, output ready);
endinterface

`default_nettype wire

@@ design/alp_rsp_if.sv @@
`default_nettype none

interface alp_rsp_if import alp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     item_kind;
   logic [CHAN_NUM_W-1:0]    channel_number;
   logic [VALUE_W-1:0]       channel_value;
   logic                     value_valid;
   logic [1:0]               line_status;
   logic [COUNTER_W-1:0]     line_counter;
   logic signed [TOFF_W-1:0] time_offset_usec;
   logic                     last_of_line;

   modport source (output valid, item_kind, channel_number, channel_value, value_valid,
                   line_status, line_counter, time_offset_usec, last_of_line,
                   input ready);
   modport sink (input valid, item_kind, channel_number, channel_value, value_valid,
                 line_status, line_counter, time_offset_usec, last_of_line,
                 output ready);
endinterface

`default_nettype wire

@@ design/alp_chan_mem.sv @@
`default_nettype none

module alp_chan_mem import alp_pkg::*; #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/alp_time_calc.sv @@
`default_nettype none

module alp_time_calc import alp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  alp_time_req_type         req,
   output logic                     done,
   output logic signed [TOFF_W-1:0] toff
);

   logic                     stage_ff;
   logic                     done_ff;
   logic [PROD_W-1:0]        product_ff;
   logic                     pps_ff;
   logic [USEC_W-1:0]        arrival_ff;
   logic signed [TOFF_W-1:0] toff_ff;
   logic signed [TOFF_W-1:0] toff_in;
   logic signed [TOFF_W-1:0] prod_s;
   logic signed [TOFF_W-1:0] arr_s;
   logic signed [TOFF_W-1:0] diff;
   logic                     far;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= req.start;
         done_ff  <= stage_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         product_ff <= PROD_W'(req.counter) * PROD_W'(req.period);
         pps_ff     <= req.pps;
         arrival_ff <= req.arrival;
      end
      if (stage_ff) begin
         toff_ff <= toff_in;
      end
   end

   always_comb begin
      prod_s  = signed'({1'b0, product_ff});
      arr_s   = signed'(TOFF_W'(arrival_ff));
      diff    = arr_s - prod_s;
      far     = (diff > FAR_LIMIT_USEC) || (diff < -FAR_LIMIT_USEC);
      toff_in = arr_s;
      if (pps_ff) begin
         toff_in = prod_s;
         if (far && arr_s > FAR_LIMIT_USEC) begin
            toff_in = prod_s + SECOND_USEC;
         end else if (far && arr_s < NEAR_START_USEC) begin
            toff_in = prod_s - SECOND_USEC;
         end
      end
   end

   assign done = done_ff;
   assign toff = toff_ff;

endmodule

`default_nettype wire

@@ design/ascii_adc_line_parser.sv @@
// ASCII ADC line parser.
// req_ch carries one character of a '#counter,v0,v1,...,checksum' line per
// transfer, with end_of_line on its last character and arrival_usec sampled there.
// rsp_ch delivers, for a good data line, one value item per enabled channel
// (channel order) and then a status item with last_of_line set; a line with a
// bad checksum or no comma gives only the status item. Other lines give nothing.
// csr_we/csr_index/csr_wdata write the four control registers; the user is to
// write them while idle, as the block itself does not enforce this.
// Throughput: one character per cycle inside a line. At line end the block holds
// req_ch.ready low through the multiply and time correction, the walk over the
// channel slots with channel memory reads, and the status item.
// A stalled rsp_ch holds the pending item in the output register and the
// sequencer waits; the last status item may wait there while the next line
// streams in.
// Reset (synchronous) restores register defaults, clears line state and
// leaves the block waiting for a line start. The channel memory needs no clear.
`default_nettype none

module ascii_adc_line_parser import alp_pkg::*; #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   alp_req_if.sink               req_ch,
   alp_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LIVE  = (NUM_CHANNELS < MAX_CHAN) ? NUM_CHANNELS : MAX_CHAN;
   localparam int IDX_W = (LIVE > 1) ? $clog2(LIVE) : 1;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_TIME = 5'b00010,
      S_READ = 5'b00100,
      S_EMIT = 5'b01000,
      S_STAT = 5'b10000
   } state_type;

   // control registers
   logic              checksum_enable_ff;
   logic              pps_locked_ff;
   logic [USEC_W-1:0] period_ff;
   logic [MASK_W-1:0] mask_ff;

   // line state
   logic [BYTE_W-1:0]    running_sum_ff, running_sum_in;
   logic [BYTE_W-1:0]    sbl_ff, sbl_in;
   logic [VALUE_W-1:0]   field_acc_ff, field_acc_in;
   logic                 has_digit_ff, has_digit_in;
   logic                 field_done_ff, field_done_in;
   logic [CC_W-1:0]      cc_ff, cc_in;
   logic                 line_is_data_ff, line_is_data_in;
   logic                 at_line_start_ff, at_line_start_in;
   logic [COUNTER_W-1:0] counter_ff, counter_in;
   logic [LIVE-1:0]      written_ff, written_in;
   logic [USEC_W-1:0]    arrival_ff, arrival_in;
   logic [1:0]           status_ff, status_in;
   logic                 start_ff, start_in;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     chan_ff, chan_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff;
   logic [CHAN_NUM_W-1:0] rsp_chan_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_vvalid_ff;
   logic [1:0]           rsp_status_ff;
   logic [COUNTER_W-1:0] rsp_counter_ff;
   logic signed [TOFF_W-1:0] rsp_toff_ff;

   logic                 req_acc;
   logic                 comma_hit;
   logic                 line_end;
   alp_hex_type          hex;
   logic [VALUE_W-1:0]   src_acc;
   logic                 src_has;
   logic [CC_W-1:0]      src_cc;
   logic [CC_W-1:0]      src_idx;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic                 mem_re;
   logic [VALUE_W-1:0]   mem_rdata;
   logic                 slot_free;
   logic                 chan_last;
   logic                 load_value;
   logic                 load_status;
   alp_time_req_type     time_req;
   logic                 time_done;
   logic signed [TOFF_W-1:0] time_toff;

   assign req_acc      = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign hex          = hex_decode(req_ch.line_byte);
   assign comma_hit    = req_acc && !at_line_start_ff && line_is_data_ff
                         && (req_ch.line_byte == COMMA_CHAR);

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         checksum_enable_ff <= 1'b1;
         pps_locked_ff      <= 1'b0;
         period_ff          <= PERIOD_RESET;
         mask_ff            <= '0;
      end else if (csr_we) begin
         unique case (alp_csr_type'(csr_index))
            CSR_CHECKSUM_ENABLE: checksum_enable_ff <= csr_wdata[0];
            CSR_PPS_LOCKED:      pps_locked_ff      <= csr_wdata[0];
            CSR_SAMPLE_PERIOD:   period_ff          <= csr_wdata[USEC_W-1:0];
            CSR_CHANNEL_MASK:    mask_ff            <= csr_wdata[MASK_W-1:0];
         endcase
      end
   end

   // character parsing
   always_comb begin
      running_sum_in   = running_sum_ff;
      sbl_in           = sbl_ff;
      field_acc_in     = field_acc_ff;
      has_digit_in     = has_digit_ff;
      field_done_in    = field_done_ff;
      cc_in            = cc_ff;
      line_is_data_in  = line_is_data_ff;
      at_line_start_in = at_line_start_ff;
      counter_in       = counter_ff;
      written_in       = written_ff;
      arrival_in       = arrival_ff;
      status_in        = status_ff;
      line_end         = 1'b0;
      mem_we           = 1'b0;

      if (req_acc) begin
         if (at_line_start_ff) begin
            at_line_start_in = 1'b0;
            line_is_data_in  = (req_ch.line_byte == HASH_CHAR);
            running_sum_in   = line_is_data_in ? req_ch.line_byte : '0;
            sbl_in           = '0;
            cc_in            = '0;
            counter_in       = '0;
            written_in       = '0;
            field_acc_in     = '0;
            has_digit_in     = 1'b0;
            field_done_in    = 1'b0;
         end else if (line_is_data_ff) begin
            running_sum_in = running_sum_ff + req_ch.line_byte;
            if (comma_hit) begin
               sbl_in        = running_sum_ff;
               cc_in         = (cc_ff != CC_MAX) ? cc_ff + 1'b1 : cc_ff;
               field_acc_in  = '0;
               has_digit_in  = 1'b0;
               field_done_in = 1'b0;
            end else if (!field_done_ff) begin
               if (!hex.ok) begin
                  field_done_in = 1'b1;
               end else begin
                  field_acc_in = (field_acc_ff[VALUE_W-1 -: 4] != 4'd0) ? '1
                                 : {field_acc_ff[VALUE_W-5:0], hex.digit};
                  has_digit_in = 1'b1;
               end
            end
         end
         if (req_ch.end_of_line) begin
            at_line_start_in = 1'b1;
            line_end         = line_is_data_in;
            arrival_in       = req_ch.arrival_usec;
         end
      end

      // commit the field that a comma or the line end closes
      if (comma_hit) begin
         src_acc = field_acc_ff;
         src_has = has_digit_ff;
         src_cc  = cc_ff;
      end else begin
         src_acc = field_acc_in;
         src_has = has_digit_in;
         src_cc  = cc_in;
      end
      src_idx   = src_cc - 1'b1;
      mem_waddr = src_idx[IDX_W-1:0];
      if (comma_hit || line_end) begin
         if (src_cc == '0) begin
            counter_in = !src_has ? '0
                         : (src_acc[VALUE_W-1:COUNTER_W] != '0) ? '1
                         : src_acc[COUNTER_W-1:0];
         end else if (src_has && src_idx < CC_W'(LIVE)) begin
            mem_we                = 1'b1;
            written_in[mem_waddr] = 1'b1;
         end
      end

      if (line_end) begin
         status_in = LS_GOOD;
         if (checksum_enable_ff) begin
            if (cc_in == '0) begin
               status_in = LS_NO_COMMA;
            end else if (!has_digit_in
                         || field_acc_in != {{(VALUE_W-BYTE_W){1'b0}}, sbl_in}) begin
               status_in = LS_BAD_SUM;
            end
         end
      end
   end

   // result sequencing
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign chan_last = (chan_ff == IDX_W'(LIVE - 1));

   always_comb begin
      state_in    = state_ff;
      chan_in     = chan_ff;
      start_in    = 1'b0;
      mem_re      = 1'b0;
      load_value  = 1'b0;
      load_status = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (line_end) begin
               start_in = 1'b1;
               state_in = S_TIME;
            end
         end
         S_TIME: begin
            if (time_done) begin
               chan_in  = '0;
               state_in = (status_ff == LS_GOOD) ? S_READ : S_STAT;
            end
         end
         S_READ: begin
            if (mask_ff[chan_ff]) begin
               mem_re   = 1'b1;
               state_in = S_EMIT;
            end else if (chan_last) begin
               state_in = S_STAT;
            end else begin
               chan_in = chan_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               load_value = 1'b1;
               if (chan_last) begin
                  state_in = S_STAT;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_STAT: begin
            if (slot_free) begin
               load_status = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ch.ready) || load_value || load_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff   <= '0;
         sbl_ff           <= '0;
         field_acc_ff     <= '0;
         has_digit_ff     <= 1'b0;
         field_done_ff    <= 1'b0;
         cc_ff            <= '0;
         line_is_data_ff  <= 1'b0;
         at_line_start_ff <= 1'b1;
         counter_ff       <= '0;
         written_ff       <= '0;
         status_ff        <= LS_GOOD;
         start_ff         <= 1'b0;
         state_ff         <= S_IDLE;
         chan_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         running_sum_ff   <= running_sum_in;
         sbl_ff           <= sbl_in;
         field_acc_ff     <= field_acc_in;
         has_digit_ff     <= has_digit_in;
         field_done_ff    <= field_done_in;
         cc_ff            <= cc_in;
         line_is_data_ff  <= line_is_data_in;
         at_line_start_ff <= at_line_start_in;
         counter_ff       <= counter_in;
         written_ff       <= written_in;
         status_ff        <= status_in;
         start_ff         <= start_in;
         state_ff         <= state_in;
         chan_ff          <= chan_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      arrival_ff <= arrival_in;
      if (load_value) begin
         rsp_kind_ff    <= KIND_VALUE;
         rsp_chan_ff    <= CHAN_NUM_W'(chan_ff);
         rsp_value_ff   <= written_ff[chan_ff] ? mem_rdata : '0;
         rsp_vvalid_ff  <= written_ff[chan_ff];
         rsp_status_ff  <= LS_GOOD;
         rsp_counter_ff <= '0;
         rsp_toff_ff    <= '0;
      end else if (load_status) begin
         rsp_kind_ff    <= KIND_STATUS;
         rsp_chan_ff    <= '0;
         rsp_value_ff   <= '0;
         rsp_vvalid_ff  <= 1'b0;
         rsp_status_ff  <= status_ff;
         rsp_counter_ff <= counter_ff;
         rsp_toff_ff    <= time_toff;
      end
   end

   assign time_req.start   = start_ff;
   assign time_req.pps     = pps_locked_ff;
   assign time_req.counter = counter_ff;
   assign time_req.period  = period_ff;
   assign time_req.arrival = arrival_ff;

   alp_time_calc u_time (
      .clock (clock),
      .reset (reset),
      .req   (time_req),
      .done  (time_done),
      .toff  (time_toff)
   );

   alp_chan_mem #(
      .DEPTH  (LIVE),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (src_acc),
      .rd_en   (mem_re),
      .rd_addr (chan_ff),
      .rd_data (mem_rdata)
   );

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.item_kind        = rsp_kind_ff;
   assign rsp_ch.channel_number   = rsp_chan_ff;
   assign rsp_ch.channel_value    = rsp_value_ff;
   assign rsp_ch.value_valid      = rsp_vvalid_ff;
   assign rsp_ch.line_status      = rsp_status_ff;
   assign rsp_ch.line_counter     = rsp_counter_ff;
   assign rsp_ch.time_offset_usec = rsp_toff_ff;
   assign rsp_ch.last_of_line     = rsp_kind_ff;

   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.last_of_line == (rsp_ch.item_kind == KIND_STATUS)))
      else $error("last_of_line disagrees with item kind");

   a_value_only_good: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.item_kind == KIND_VALUE) |-> (status_ff == LS_GOOD))
      else $error("value item for a line with bad status");

   a_write_while_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_IDLE))
      else $error("channel memory write outside line parsing");

   a_time_done_wait: assert property (@(posedge clock) disable iff (reset)
      time_done |-> (state_ff == S_TIME))
      else $error("time result arrived while not waiting for it");

   a_start_to_done: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> ##2 time_done)
      else $error("time unit latency broken");

endmodule

`default_nettype wire
